>>> hw/rtl/lzss_flag_byte_decoder_assert.svh
// ----------------------------------------------------------------------------
// LZSS flag-byte decoder assertion macros
// Shared helpers for the concurrent checks at the end of the RTL modules.
// ----------------------------------------------------------------------------
`ifndef LZSS_FLAG_BYTE_DECODER_ASSERT_SVH
`define LZSS_FLAG_BYTE_DECODER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define LFBD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define LFBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/lfbd_pkg.sv
// ----------------------------------------------------------------------------
// LZSS flag-byte decoder package
// Command, event, state and configuration types shared by the decoder modules.
// ----------------------------------------------------------------------------
package lfbd_pkg;

  // Token command handed from the front end to the copy engine
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_LIT,
    CMD_COPY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] data;   // literal in [7:0], or the full 16-bit code
    logic        last;
  } cmd_t;

  typedef enum logic [1:0] {
    FR_FLAG,
    FR_TOKEN,
    FR_CODE_LOW
  } front_state_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_WRITE
  } back_state_t;

  // One decoded output byte, or an end-of-stream marker
  typedef struct packed {
    logic       valid;
    logic       marker;
    logic [7:0] data;
    logic       final_byte;
    logic       last;
  } byte_evt_t;

  typedef struct packed {
    logic [3:0]  offset_shift;
    logic [5:0]  length_mask;
    logic [1:0]  length_bias;
    logic [23:0] output_limit;
  } cfg_t;

  typedef enum logic [1:0] {
    REG_OFFSET_SHIFT,
    REG_LENGTH_MASK,
    REG_LENGTH_BIAS,
    REG_OUTPUT_LIMIT
  } cfg_reg_t;

  localparam logic [3:0]  OFFSET_SHIFT_RST = 4'd10;
  localparam logic [5:0]  LENGTH_MASK_RST  = 6'd63;
  localparam logic [1:0]  LENGTH_BIAS_RST  = 2'd3;
  localparam logic [23:0] OUTPUT_LIMIT_RST = 24'hFFFFFF;

  localparam int CMD_FIFO_DEPTH = 4;
  localparam int CMD_PTR_W      = 2;

endpackage

>>> hw/rtl/lfbd_front.sv
// ----------------------------------------------------------------------------
// LZSS decoder front end
// Tracks flag bytes and token phase, turns input bytes into commands.
// ----------------------------------------------------------------------------
module lfbd_front (
  input  logic           clk,
  input  logic           rst,
  input  lfbd_pkg::cfg_t cfg,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [7:0]     s_axis_tdata,   // [7:0] in_byte
  input  logic           s_axis_tlast,   // in_last
  input  logic           fifo_full,
  input  logic           clear_busy,
  output logic           push,
  output lfbd_pkg::cmd_t cmd
);
  import lfbd_pkg::*;

  front_state_t state;
  front_state_t state_next;
  logic [7:0]   flag_bits;
  logic [7:0]   flag_bits_next;
  logic [2:0]   flag_index;
  logic [2:0]   flag_index_next;
  logic [7:0]   code_high;
  logic [7:0]   code_high_next;
  logic [23:0]  produced;
  logic [23:0]  produced_next;
  logic         under_limit;
  logic [6:0]   len_sum;
  logic [6:0]   copy_len;
  logic [23:0]  room;
  logic         accept;

  assign s_axis_tready = !fifo_full && !clear_busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // byte count of the stream, kept in step with the copy engine
  assign under_limit = (produced < cfg.output_limit);
  assign len_sum     = {1'b0, s_axis_tdata[5:0] & cfg.length_mask} +
                       {5'd0, cfg.length_bias};
  assign copy_len    = (len_sum <= 7'd1) ? 7'd0 : (len_sum - 7'd1);
  assign room        = cfg.output_limit - produced;

  // next state
  always_comb begin
    state_next      = state;
    flag_bits_next  = flag_bits;
    flag_index_next = flag_index;
    code_high_next  = code_high;
    produced_next   = produced;
    if (accept) begin
      // past the output limit, hold the token state until the stream ends
      if (under_limit) begin
        unique case (state)
          FR_FLAG: begin
            flag_bits_next  = s_axis_tdata;
            flag_index_next = 3'd0;
            state_next      = FR_TOKEN;
          end
          FR_TOKEN: begin
            if (flag_bits[7]) begin
              code_high_next = s_axis_tdata;
              state_next     = FR_CODE_LOW;
            end else begin
              flag_bits_next  = {flag_bits[6:0], 1'b0};
              flag_index_next = flag_index + 3'd1;
              state_next      = (flag_index == 3'd7) ? FR_FLAG : FR_TOKEN;
              produced_next   = produced + 24'd1;
            end
          end
          FR_CODE_LOW: begin
            flag_bits_next  = {flag_bits[6:0], 1'b0};
            flag_index_next = flag_index + 3'd1;
            state_next      = (flag_index == 3'd7) ? FR_FLAG : FR_TOKEN;
            produced_next   = (room <= {17'd0, copy_len}) ? cfg.output_limit :
                              (produced + {17'd0, copy_len});
          end
          default: state_next = FR_FLAG;
        endcase
      end
      // end of stream: drop token state, including a dangling code byte
      if (s_axis_tlast) begin
        state_next      = FR_FLAG;
        flag_bits_next  = 8'd0;
        flag_index_next = 3'd0;
        code_high_next  = 8'd0;
        produced_next   = 24'd0;
      end
    end
  end

  // outputs
  always_comb begin
    cmd.kind = CMD_NONE;
    cmd.data = {8'd0, s_axis_tdata};
    cmd.last = s_axis_tlast;
    unique case (state)
      FR_FLAG:     cmd.kind = CMD_NONE;
      FR_TOKEN:    cmd.kind = flag_bits[7] ? CMD_NONE : CMD_LIT;
      FR_CODE_LOW: begin
        cmd.kind = CMD_COPY;
        cmd.data = {code_high, s_axis_tdata};
      end
      default:     cmd.kind = CMD_NONE;
    endcase
    if (!under_limit) begin
      cmd.kind = CMD_NONE;
    end
    push = accept && ((cmd.kind != CMD_NONE) || s_axis_tlast);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= FR_FLAG;
      flag_bits  <= 8'd0;
      flag_index <= 3'd0;
      code_high  <= 8'd0;
      produced   <= 24'd0;
    end else begin
      state      <= state_next;
      flag_bits  <= flag_bits_next;
      flag_index <= flag_index_next;
      code_high  <= code_high_next;
      produced   <= produced_next;
    end
  end

endmodule

>>> hw/rtl/lfbd_cmd_fifo.sv
// ----------------------------------------------------------------------------
// LZSS decoder command queue
// Short register queue between the front end and the copy engine.
// ----------------------------------------------------------------------------
module lfbd_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lfbd_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output lfbd_pkg::cmd_t head,
  output logic           head_valid
);
  import lfbd_pkg::*;

  cmd_t                 entries [CMD_FIFO_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_PTR_W:0]   count;

  assign full       = (count == (CMD_PTR_W + 1)'(CMD_FIFO_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/lfbd_back.sv
// ----------------------------------------------------------------------------
// LZSS decoder copy engine
// Executes literal and copy commands against the history memory.
// ----------------------------------------------------------------------------
`include "lzss_flag_byte_decoder_assert.svh"

module lfbd_back #(
  parameter int HISTORY_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  lfbd_pkg::cfg_t      cfg,
  input  lfbd_pkg::cmd_t      head,
  input  logic                head_valid,
  output logic                pop,
  input  logic                evt_ready,
  output lfbd_pkg::byte_evt_t evt,
  output logic                clear_busy
);
  import lfbd_pkg::*;

  // the user must keep the depth a power of two, unchecked here, so pointer arithmetic wraps by itself
  localparam int HIST_AW = $clog2(HISTORY_DEPTH);

  back_state_t        state;
  back_state_t        state_next;
  logic [HIST_AW-1:0] hist_ptr;
  logic [HIST_AW-1:0] clr_addr;
  logic [HIST_AW-1:0] back_dist;
  logic [23:0]        produced;
  logic [23:0]        produced_inc;
  logic [6:0]         remaining;
  logic               copy_last;
  logic [7:0]         rd_data;
  logic [7:0]         hist_mem [HISTORY_DEPTH];

  logic               mem_we;
  logic               mem_re;
  logic [HIST_AW-1:0] mem_waddr;
  logic [HIST_AW-1:0] mem_raddr;
  logic [7:0]         mem_wdata;

  logic [5:0]         len_masked;
  logic [6:0]         len_sum;
  logic               len_empty;
  logic [15:0]        offset16;
  logic               under_limit;
  logic               at_end;

  assign len_masked   = head.data[5:0] & cfg.length_mask;
  assign len_sum      = {1'b0, len_masked} + {5'd0, cfg.length_bias};
  assign len_empty    = (len_sum <= 7'd1);
  assign offset16     = head.data >> cfg.offset_shift;
  assign under_limit  = (produced < cfg.output_limit);
  assign produced_inc = produced + 24'd1;
  assign at_end       = (produced_inc >= cfg.output_limit);
  assign mem_raddr    = hist_ptr - back_dist;
  assign clear_busy   = (state == BK_CLEAR);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_CLEAR: begin
        if (clr_addr == HIST_AW'(HISTORY_DEPTH - 1)) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (head_valid && evt_ready && (head.kind == CMD_COPY) && under_limit &&
            !len_empty) begin
          state_next = BK_READ;
        end
      end
      BK_READ: state_next = BK_WRITE;
      BK_WRITE: begin
        if (evt_ready) begin
          state_next = ((remaining == 7'd1) || at_end) ? BK_IDLE : BK_READ;
        end
      end
      default: state_next = BK_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    pop       = 1'b0;
    evt       = '0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = hist_ptr;
    mem_wdata = rd_data;
    unique case (state)
      BK_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = 8'd0;
      end
      BK_IDLE: begin
        if (head_valid && evt_ready) begin
          pop = 1'b1;
          case (head.kind)
            CMD_LIT: begin
              if (under_limit) begin
                evt.valid      = 1'b1;
                evt.data       = head.data[7:0];
                evt.final_byte = 1'b1;
                evt.last       = head.last;
                mem_we         = 1'b1;
                mem_wdata      = head.data[7:0];
              end else if (head.last) begin
                evt.valid  = 1'b1;
                evt.marker = 1'b1;
                evt.last   = 1'b1;
              end
            end
            CMD_COPY: begin
              if ((!under_limit || len_empty) && head.last) begin
                evt.valid  = 1'b1;
                evt.marker = 1'b1;
                evt.last   = 1'b1;
              end
            end
            default: begin
              if (head.last) begin
                evt.valid  = 1'b1;
                evt.marker = 1'b1;
                evt.last   = 1'b1;
              end
            end
          endcase
        end
      end
      BK_READ: mem_re = 1'b1;
      BK_WRITE: begin
        if (evt_ready) begin
          mem_we         = 1'b1;
          evt.valid      = 1'b1;
          evt.data       = rd_data;
          evt.final_byte = (remaining == 7'd1) || at_end;
          evt.last       = copy_last;
        end
      end
      default: pop = 1'b0;
    endcase
  end

  // history memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= hist_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (head.kind == CMD_COPY)) begin
      back_dist <= offset16[HIST_AW-1:0];
      copy_last <= head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      clr_addr  <= '0;
      hist_ptr  <= '0;
      produced  <= 24'd0;
      remaining <= 7'd0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (evt.valid) begin
        if (evt.marker || (evt.final_byte && evt.last)) begin
          produced <= 24'd0;
        end else begin
          produced <= produced_inc;
        end
        if (!evt.marker) begin
          hist_ptr <= hist_ptr + 1'b1;
        end
      end
      if (pop && (head.kind == CMD_COPY)) begin
        remaining <= len_sum - 7'd1;
      end else if ((state == BK_WRITE) && evt_ready) begin
        remaining <= remaining - 7'd1;
      end
    end
  end

  `LFBD_ASSERT_IMPLY(a_copy_has_bytes, clk, rst, (state == BK_READ || state == BK_WRITE), (remaining != 7'd0), "copy running with no bytes left")
  `LFBD_ASSERT_IMPLY(a_byte_under_limit, clk, rst, (evt.valid && !evt.marker), (produced < cfg.output_limit), "byte emitted past output limit")
  `LFBD_ASSERT_NEXT(a_marker_clears_count, clk, rst, (evt.valid && evt.marker), (produced == 24'd0), "byte count not cleared after end marker")

endmodule

>>> hw/rtl/lfbd_packer.sv
// ----------------------------------------------------------------------------
// LZSS decoder output packer
// Pairs decoded bytes into results and holds them in the output register.
// ----------------------------------------------------------------------------
`include "lzss_flag_byte_decoder_assert.svh"

module lfbd_packer (
  input  logic                clk,
  input  logic                rst,
  input  lfbd_pkg::byte_evt_t evt,
  output logic                evt_ready,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata,   // [7:0] first_byte, [15:8] second_byte,
                                              // [17:16] byte_count, [23:18] zero
  output logic                m_axis_tlast    // last_result
);
  import lfbd_pkg::*;

  logic       out_valid;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [1:0] byte_count;
  logic       last_result;
  logic       half_valid;
  logic [7:0] half_byte;

  assign evt_ready     = !out_valid || m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, byte_count, second_byte, first_byte};
  assign m_axis_tlast  = last_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      half_valid <= 1'b0;
    end else begin
      if (evt.valid && (evt.marker || half_valid || evt.final_byte)) begin
        out_valid  <= 1'b1;
        half_valid <= 1'b0;
      end else begin
        if (evt.valid) begin
          half_valid <= 1'b1;
        end
        if (m_axis_tready) begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid) begin
      if (evt.marker) begin
        first_byte  <= 8'd0;
        second_byte <= 8'd0;
        byte_count  <= 2'd0;
        last_result <= 1'b1;
      end else if (half_valid) begin
        first_byte  <= half_byte;
        second_byte <= evt.data;
        byte_count  <= 2'd2;
        last_result <= evt.final_byte && evt.last;
      end else if (evt.final_byte) begin
        first_byte  <= evt.data;
        second_byte <= 8'd0;
        byte_count  <= 2'd1;
        last_result <= evt.last;
      end else begin
        half_byte <= evt.data;
      end
    end
  end

  `LFBD_ASSERT_IMPLY(a_marker_no_half, clk, rst, (evt.valid && evt.marker), (!half_valid), "end marker while a byte is pending")

endmodule

>>> hw/rtl/lzss_flag_byte_decoder.sv
// ----------------------------------------------------------------------------
// LZSS flag-byte decoder
// Decompresses a flag-byte LZSS stream with 16-bit back-reference codes.
// ----------------------------------------------------------------------------
// Compressed bytes enter on the s_axis stream, one byte per transaction, with
// tlast on the final byte of a stream. Results leave on m_axis, up to two
// decoded bytes each; tlast marks the final result of a stream, and a stream
// that ends without new bytes yields one result with byte_count zero.
// The cfg channel writes the four registers (offset shift, length mask,
// length bias, output limit); write them only while the block is idle.
// Flag bytes, code high bytes and literals are taken one per cycle while s_axis_tready is high.
// For each output byte of a copy the history memory is read, then written
// with the same byte, through its single read and write ports.
// The command for a byte is registered in the command queue, and its result in the output register.
// After reset the history memory is cleared, one entry per cycle, over all
// HISTORY_DEPTH entries; s_axis_tready stays low during that pass while
// cfg writes are still taken. HISTORY_DEPTH must be a power of two.
// A stalled m_axis holds its result; a four-entry command queue keeps
// s_axis accepting bytes until it fills, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module lzss_flag_byte_decoder #(
  parameter int HISTORY_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // in_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] first_byte, [15:8] second_byte,
                                      // [17:16] byte_count, [23:18] zero
  output logic        m_axis_tlast,   // last_result
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import lfbd_pkg::*;

  cfg_t      cfg;
  cmd_t      push_cmd;
  cmd_t      head;
  logic      push;
  logic      pop;
  logic      full;
  logic      head_valid;
  logic      clear_busy;
  logic      evt_ready;
  byte_evt_t evt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_shift <= OFFSET_SHIFT_RST;
      cfg.length_mask  <= LENGTH_MASK_RST;
      cfg.length_bias  <= LENGTH_BIAS_RST;
      cfg.output_limit <= OUTPUT_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_OFFSET_SHIFT: cfg.offset_shift <= cfg_data[3:0];
        REG_LENGTH_MASK:  cfg.length_mask  <= cfg_data[5:0];
        REG_LENGTH_BIAS:  cfg.length_bias  <= cfg_data[1:0];
        REG_OUTPUT_LIMIT: cfg.output_limit <= cfg_data;
        default:          cfg.output_limit <= cfg.output_limit;
      endcase
    end
  end

  lfbd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .fifo_full     (full),
    .clear_busy    (clear_busy),
    .push          (push),
    .cmd           (push_cmd)
  );

  lfbd_cmd_fifo u_cmd_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_cmd),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  lfbd_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .evt_ready  (evt_ready),
    .evt        (evt),
    .clear_busy (clear_busy)
  );

  lfbd_packer u_packer (
    .clk           (clk),
    .rst           (rst),
    .evt           (evt),
    .evt_ready     (evt_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
